>>> rtl/mfd_pkg.sv
// Shared constants for the moveable feast dates pipeline.
// No dependencies.
`timescale 1ns / 1ps

package mfd_pkg;

	localparam int YEAR_W = 14;

	// Reciprocal multipliers for division by constants, with their shifts.
	// Each one is exact over the value range that reaches it.
	localparam int RCP100  = 5243;   // y / 100, y < 16384
	localparam int SH100   = 19;
	localparam int RCP19   = 27595;  // y / 19,  y < 16384
	localparam int SH19    = 19;
	localparam int RCP25   = 41;     // x / 25,  x < 172
	localparam int SH25    = 10;
	localparam int RCP3    = 171;    // x / 3,   x < 165
	localparam int SH3     = 9;
	localparam int RCP30   = 2185;   // x / 30,  x < 611
	localparam int SH30    = 16;
	localparam int RCP7    = 147;    // x / 7,   x < 157
	localparam int SH7     = 10;

	// Computus constants
	localparam int EPACT_OFS  = 105;  // 15 plus a multiple of 30 to keep the sum positive
	localparam int DOW_OFS    = 102;  // 32 + 70
	localparam int M_LIMIT    = 451;
	localparam int MAR1_OFS   = 21;   // 114 - 93: Easter counted from March 1

	// Month codes, 1 = January
	localparam logic [2:0] MON_FEB = 3'd2;
	localparam logic [2:0] MON_MAR = 3'd3;
	localparam logic [2:0] MON_APR = 3'd4;
	localparam logic [2:0] MON_MAY = 3'd5;
	localparam logic [2:0] MON_JUN = 3'd6;

endpackage

>>> rtl/moveable_feast_dates_unit.sv
// Moveable feast dates: Easter and four dependent feasts for a Gregorian year.
// Depends on mfd_pkg.
`timescale 1ns / 1ps

// A year is taken on every clock edge where start is high; busy never rises,
// so the unit accepts one year per cycle without gaps. In the ten-stage
// pipeline a year's dates are registered by stage 10; they sit on the date
// ports for the following cycle, marked by done. Results leave in the order
// the years came in; the receiver cannot hold them off and none is needed,
// since every stage advances on every cycle. The stages follow the chain
// of constant divisions in the computus (year split, epact, weekday,
// correction). Any 14-bit year is evaluated with Gregorian leap rules,
// proleptic below 1583.
module moveable_feast_dates_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [13:0] year,
	output logic        done,
	output logic [4:0]  carnival_day,
	output logic [1:0]  carnival_month,
	output logic [4:0]  good_friday_day,
	output logic [2:0]  good_friday_month,
	output logic [4:0]  easter_dom,
	output logic [2:0]  easter_mon,
	output logic [4:0]  ascension_day,
	output logic [2:0]  ascension_month,
	output logic [4:0]  whitsun_day,
	output logic [2:0]  whitsun_month
);

	// Pipeline never stalls.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Valid bits, one per stage
	logic [10:1] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[9:1], accept};
		end
	end

	assign done = vld_q[10];

	// ---------------------------------------------------------------
	// Stage 1: century b = y / 100 and y / 19 by reciprocal multiply
	// ---------------------------------------------------------------
	logic [27:0] prod_b;
	logic [28:0] prod_q19;
	logic [13:0] y_s1;
	logic [7:0]  b_s1;
	logic [9:0]  q19_s1;

	assign prod_b   = 28'(year) * 28'(mfd_pkg::RCP100);
	assign prod_q19 = 29'(year) * 29'(mfd_pkg::RCP19);

	always_ff @(posedge clk) begin
		y_s1   <= year;
		b_s1   <= prod_b[mfd_pkg::SH100 +: 8];
		q19_s1 <= prod_q19[mfd_pkg::SH19 +: 10];
	end

	// ---------------------------------------------------------------
	// Stage 2: a = y % 19, c = y % 100, f = (b + 8) / 25
	// ---------------------------------------------------------------
	logic [13:0] a_full, c_full;
	logic [12:0] f_prod;
	logic [4:0]  a_s2;
	logic [6:0]  c_s2;
	logic [7:0]  b_s2;
	logic [2:0]  f_s2;
	logic [1:0]  ylo_s2;

	assign a_full = y_s1 - 14'(14'(q19_s1) * 14'd19);
	assign c_full = y_s1 - 14'(14'(b_s1) * 14'd100);
	assign f_prod = (13'(b_s1) + 13'd8) * 13'(mfd_pkg::RCP25);

	always_ff @(posedge clk) begin
		a_s2   <= a_full[4:0];
		c_s2   <= c_full[6:0];
		b_s2   <= b_s1;
		f_s2   <= f_prod[mfd_pkg::SH25 +: 3];
		ylo_s2 <= y_s1[1:0];
	end

	// ---------------------------------------------------------------
	// Stage 3: g = (b - f + 1) / 3, leap year flag
	// ---------------------------------------------------------------
	logic [7:0]  g_arg;
	logic [15:0] g_prod;
	logic [4:0]  a_s3;
	logic [6:0]  c_s3;
	logic [7:0]  b_s3;
	logic [5:0]  g_s3;
	logic        leap_s3;

	assign g_arg  = b_s2 - 8'(f_s2) + 8'd1;
	assign g_prod = 16'(g_arg) * 16'(mfd_pkg::RCP3);

	always_ff @(posedge clk) begin
		a_s3    <= a_s2;
		c_s3    <= c_s2;
		b_s3    <= b_s2;
		g_s3    <= g_prod[mfd_pkg::SH3 +: 6];
		// y % 400 == 0 is c == 0 with b % 4 == 0
		leap_s3 <= ((ylo_s2 == 2'd0) && (c_s2 != 7'd0)) ||
		           ((c_s2 == 7'd0) && (b_s2[1:0] == 2'd0));
	end

	// ---------------------------------------------------------------
	// Stage 4: epact sum 19a + b + 15 - d - g (kept positive)
	// ---------------------------------------------------------------
	logic [9:0] hsum;
	logic [9:0] hsum_s4;
	logic [4:0] a_s4;
	logic [6:0] c_s4;
	logic [1:0] e_s4;
	logic       leap_s4;

	assign hsum = 10'(10'd19 * 10'(a_s3)) + 10'(b_s3) + 10'(mfd_pkg::EPACT_OFS)
	            - 10'(b_s3[7:2]) - 10'(g_s3);

	always_ff @(posedge clk) begin
		hsum_s4 <= hsum;
		a_s4    <= a_s3;
		c_s4    <= c_s3;
		e_s4    <= b_s3[1:0];
		leap_s4 <= leap_s3;
	end

	// ---------------------------------------------------------------
	// Stage 5: h = hsum % 30
	// ---------------------------------------------------------------
	logic [20:0] h_prod;
	logic [9:0]  h_full;
	logic [4:0]  h_s5;
	logic [4:0]  a_s5;
	logic [6:0]  c_s5;
	logic [1:0]  e_s5;
	logic        leap_s5;

	assign h_prod = 21'(hsum_s4) * 21'(mfd_pkg::RCP30);
	assign h_full = hsum_s4 - 10'(10'(h_prod[mfd_pkg::SH30 +: 5]) * 10'd30);

	always_ff @(posedge clk) begin
		h_s5    <= h_full[4:0];
		a_s5    <= a_s4;
		c_s5    <= c_s4;
		e_s5    <= e_s4;
		leap_s5 <= leap_s4;
	end

	// ---------------------------------------------------------------
	// Stage 6: weekday sum 32 + 2e + 2i + 70 - h - k
	// ---------------------------------------------------------------
	logic [7:0] lsum;
	logic [7:0] lsum_s6;
	logic [4:0] h_s6;
	logic [4:0] a_s6;
	logic       leap_s6;

	assign lsum = 8'(mfd_pkg::DOW_OFS) + {5'd0, e_s5, 1'b0} + {2'd0, c_s5[6:2], 1'b0}
	            - 8'(h_s5) - 8'(c_s5[1:0]);

	always_ff @(posedge clk) begin
		lsum_s6 <= lsum;
		h_s6    <= h_s5;
		a_s6    <= a_s5;
		leap_s6 <= leap_s5;
	end

	// ---------------------------------------------------------------
	// Stage 7: l = lsum % 7
	// ---------------------------------------------------------------
	logic [14:0] l_prod;
	logic [7:0]  l_full;
	logic [2:0]  l_s7;
	logic [4:0]  h_s7;
	logic [4:0]  a_s7;
	logic        leap_s7;

	assign l_prod = 15'(lsum_s6) * 15'(mfd_pkg::RCP7);
	assign l_full = lsum_s6 - 8'(8'(l_prod[mfd_pkg::SH7 +: 5]) * 8'd7);

	always_ff @(posedge clk) begin
		l_s7    <= l_full[2:0];
		h_s7    <= h_s6;
		a_s7    <= a_s6;
		leap_s7 <= leap_s6;
	end

	// ---------------------------------------------------------------
	// Stage 8: m = (a + 11h + 22l) / 451, which is 0 or 1
	// ---------------------------------------------------------------
	logic [8:0] msum;
	logic       m_s8;
	logic [4:0] h_s8;
	logic [2:0] l_s8;
	logic       leap_s8;

	assign msum = 9'(a_s7) + 9'(9'd11 * 9'(h_s7)) + 9'(9'd22 * 9'(l_s7));

	always_ff @(posedge clk) begin
		m_s8    <= (msum >= 9'(mfd_pkg::M_LIMIT));
		h_s8    <= h_s7;
		l_s8    <= l_s7;
		leap_s8 <= leap_s7;
	end

	// ---------------------------------------------------------------
	// Stage 9: Easter as days after March 1 (0 = March 1)
	// ---------------------------------------------------------------
	logic [5:0] e0_s9;
	logic       leap_s9;

	always_ff @(posedge clk) begin
		e0_s9   <= 6'(h_s8) + 6'(l_s8) + 6'(mfd_pkg::MAR1_OFS) - (m_s8 ? 6'd7 : 6'd0);
		leap_s9 <= leap_s8;
	end

	// ---------------------------------------------------------------
	// Stage 10: month and day of each feast. Month starts from March 1:
	// April 31, May 61, June 92. February has 28 + leap days.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		// Carnival: Easter - 49
		if (e0_s9 >= 6'd49) begin
			carnival_month <= mfd_pkg::MON_MAR[1:0];
			carnival_day   <= 5'(e0_s9 - 6'd48);
		end else begin
			carnival_month <= mfd_pkg::MON_FEB[1:0];
			carnival_day   <= 5'(e0_s9 - 6'd20 + 6'(leap_s9));
		end

		// Good Friday: Easter - 2
		if (e0_s9 < 6'd33) begin
			good_friday_month <= mfd_pkg::MON_MAR;
			good_friday_day   <= 5'(e0_s9 - 6'd1);
		end else begin
			good_friday_month <= mfd_pkg::MON_APR;
			good_friday_day   <= 5'(e0_s9 - 6'd32);
		end

		// Easter
		if (e0_s9 < 6'd31) begin
			easter_mon <= mfd_pkg::MON_MAR;
			easter_dom <= 5'(e0_s9 + 6'd1);
		end else begin
			easter_mon <= mfd_pkg::MON_APR;
			easter_dom <= 5'(e0_s9 - 6'd30);
		end

		// Ascension: Easter + 39
		if (e0_s9 < 6'd22) begin
			ascension_month <= mfd_pkg::MON_APR;
			ascension_day   <= 5'(e0_s9 + 6'd9);
		end else if (e0_s9 < 6'd53) begin
			ascension_month <= mfd_pkg::MON_MAY;
			ascension_day   <= 5'(e0_s9 - 6'd21);
		end else begin
			ascension_month <= mfd_pkg::MON_JUN;
			ascension_day   <= 5'(e0_s9 - 6'd52);
		end

		// Whitsunday: Easter + 49
		if (e0_s9 < 6'd43) begin
			whitsun_month <= mfd_pkg::MON_MAY;
			whitsun_day   <= 5'(e0_s9 - 6'd11);
		end else begin
			whitsun_month <= mfd_pkg::MON_JUN;
			whitsun_day   <= 5'(e0_s9 - 6'd42);
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_h_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[6] |-> (h_s6 < 5'd30))
		else $error("epact remainder out of range");

	a_easter_window: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[10] |-> ((easter_mon == mfd_pkg::MON_MAR && easter_dom >= 5'd22) ||
		               (easter_mon == mfd_pkg::MON_APR && easter_dom <= 5'd25)))
		else $error("Easter outside March 22 .. April 25");

	a_good_friday: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[10] && easter_mon == mfd_pkg::MON_APR && easter_dom >= 5'd3) |->
		(good_friday_month == mfd_pkg::MON_APR && good_friday_day == 5'(easter_dom - 5'd2)))
		else $error("Good Friday not two days before Easter");

	a_whitsun: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[10] && whitsun_month == ascension_month) |->
		(whitsun_day == 5'(ascension_day + 5'd10)))
		else $error("Whitsunday not ten days after Ascension");

endmodule

>>> tb/moveable_feast_dates_unit_test.sv
// Self-checking bench for moveable_feast_dates_unit: typed and predicted dates per year.
// Depends on mfd_pkg and the unit under test; nothing else.
`timescale 1ns / 1ps

module moveable_feast_dates_unit_test;

	// One result beat, field widths as on the unit's ports
	typedef struct packed {
		logic [4:0] carnival_day;
		logic [1:0] carnival_month;
		logic [4:0] good_friday_day;
		logic [2:0] good_friday_month;
		logic [4:0] easter_dom;
		logic [2:0] easter_mon;
		logic [4:0] ascension_day;
		logic [2:0] ascension_month;
		logic [4:0] whitsun_day;
		logic [2:0] whitsun_month;
	} feast_dates_t;

	// Directed row: a year, and the dates typed in where they are well known
	typedef struct {
		int           yr;
		bit           typed;
		feast_dates_t dates;
	} year_row_t;

	localparam int N_DIRECTED   = 20;
	localparam int N_PER_PHASE  = 375;
	localparam int WATCHDOG_MAX = 2000;
	localparam int DRAIN_CYCLES = 20;   // pipeline is ten deep; margin on top

	localparam feast_dates_t NO_DATES = '0;

	// Typed rows: the earliest (2285) and latest (2038) Easter, two leap years
	// with Easter known from the calendar (2000, 2024). All others go through
	// the predictor: range ends, years outside the Gregorian range, century
	// years, a leap year with Carnival on Feb 29 (1976), years where the
	// epact correction kicks in (1954, 1981), and alternating bit patterns.
	year_row_t year_rows [N_DIRECTED] = '{
		'{2024, 1'b1, '{5'd11, mfd_pkg::MON_FEB[1:0], 5'd29, mfd_pkg::MON_MAR,
			5'd31, mfd_pkg::MON_MAR, 5'd9, mfd_pkg::MON_MAY, 5'd19, mfd_pkg::MON_MAY}},
		'{2000, 1'b1, '{5'd5, mfd_pkg::MON_MAR[1:0], 5'd21, mfd_pkg::MON_APR,
			5'd23, mfd_pkg::MON_APR, 5'd1, mfd_pkg::MON_JUN, 5'd11, mfd_pkg::MON_JUN}},
		'{2285, 1'b1, '{5'd1, mfd_pkg::MON_FEB[1:0], 5'd20, mfd_pkg::MON_MAR,
			5'd22, mfd_pkg::MON_MAR, 5'd30, mfd_pkg::MON_APR, 5'd10, mfd_pkg::MON_MAY}},
		'{2038, 1'b1, '{5'd7, mfd_pkg::MON_MAR[1:0], 5'd23, mfd_pkg::MON_APR,
			5'd25, mfd_pkg::MON_APR, 5'd3, mfd_pkg::MON_JUN, 5'd13, mfd_pkg::MON_JUN}},
		'{1583,  1'b0, NO_DATES},
		'{9999,  1'b0, NO_DATES},
		'{0,     1'b0, NO_DATES},
		'{1,     1'b0, NO_DATES},
		'{1582,  1'b0, NO_DATES},
		'{16383, 1'b0, NO_DATES},
		'{8191,  1'b0, NO_DATES},
		'{8192,  1'b0, NO_DATES},
		'{1700,  1'b0, NO_DATES},
		'{1900,  1'b0, NO_DATES},
		'{1976,  1'b0, NO_DATES},
		'{1981,  1'b0, NO_DATES},
		'{1954,  1'b0, NO_DATES},
		'{4095,  1'b0, NO_DATES},
		'{10922, 1'b0, NO_DATES},
		'{5461,  1'b0, NO_DATES}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [mfd_pkg::YEAR_W-1:0] year;
	logic                       done;
	logic [4:0]                 carnival_day;
	logic [1:0]                 carnival_month;
	logic [4:0]                 good_friday_day;
	logic [2:0]                 good_friday_month;
	logic [4:0]                 easter_dom;
	logic [2:0]                 easter_mon;
	logic [4:0]                 ascension_day;
	logic [2:0]                 ascension_month;
	logic [4:0]                 whitsun_day;
	logic [2:0]                 whitsun_month;

	// Typed dates ride along with start so the monitor sees them on the
	// accepting edge; driven nonblocking like the unit's inputs.
	logic         use_typed;
	feast_dates_t typed_dates;

	feast_dates_t dates_due[$];   // expected dates, oldest first
	int           mismatches;
	int           quiet_cycles = 0;

	moveable_feast_dates_unit u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.year              (year),
		.done              (done),
		.carnival_day      (carnival_day),
		.carnival_month    (carnival_month),
		.good_friday_day   (good_friday_day),
		.good_friday_month (good_friday_month),
		.easter_dom        (easter_dom),
		.easter_mon        (easter_mon),
		.ascension_day     (ascension_day),
		.ascension_month   (ascension_month),
		.whitsun_day       (whitsun_day),
		.whitsun_month     (whitsun_month)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Date predictor
	// ---------------------------------------------------------------

	// Days in month m of year y, Gregorian leap rule, proleptic for any year
	function automatic int month_days(int y, int m);
		case (m)
			2:           return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// Day of year (1-based) to day of month and month
	function automatic void ordinal_to_date(int y, int ord, output int dom, output int mon);
		mon = 1;
		while (mon < 12 && ord > month_days(y, mon)) begin
			ord -= month_days(y, mon);
			mon++;
		end
		dom = ord;
	endfunction

	function automatic feast_dates_t feast_dates_of(logic [mfd_pkg::YEAR_W-1:0] yr);
		int y, a, b, c, d, e, f, g, h, i, k, l, m, base;
		int emon, eday, ord, dom, mon;
		feast_dates_t r;
		y = int'(yr);
		// anonymous Gregorian computus
		a = y % 19;
		b = y / 100;
		c = y % 100;
		d = b / 4;
		e = b % 4;
		f = (b + 8) / 25;
		g = (b - f + 1) / 3;
		h = (19 * a + b + 15 + 6000 - d - g) % 30;   // 6000 keeps the sum positive
		i = c / 4;
		k = c % 4;
		l = (32 + 2 * e + 2 * i + 70 - h - k) % 7;
		m = (a + 11 * h + 22 * l) / 451;
		base = h + l + 114 - 7 * m;
		emon = base / 31;
		eday = base % 31 + 1;
		// Easter as a day of the year
		ord = eday;
		for (int j = 1; j < emon; j++)
			ord += month_days(y, j);
		r.easter_dom = 5'(eday);
		r.easter_mon = 3'(emon);
		ordinal_to_date(y, ord - 49, dom, mon);
		r.carnival_day   = 5'(dom);
		r.carnival_month = 2'(mon);
		ordinal_to_date(y, ord - 2, dom, mon);
		r.good_friday_day   = 5'(dom);
		r.good_friday_month = 3'(mon);
		ordinal_to_date(y, ord + 39, dom, mon);
		r.ascension_day   = 5'(dom);
		r.ascension_month = 3'(mon);
		ordinal_to_date(y, ord + 49, dom, mon);
		r.whitsun_day   = 5'(dom);
		r.whitsun_month = 3'(mon);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Monitor: records accepted years, checks done beats, watchdog
	// ---------------------------------------------------------------

	function automatic void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		feast_dates_t exp_dates;
		if (arst_n) begin
			// result beat first: it belongs to a year taken earlier
			if (done) begin
				if (dates_due.size() == 0) begin
					$error("done with no year outstanding");
					mismatches++;
				end else begin
					exp_dates = dates_due.pop_front();
					check_field("carnival_day", int'(exp_dates.carnival_day),
						int'(carnival_day));
					check_field("carnival_month", int'(exp_dates.carnival_month),
						int'(carnival_month));
					check_field("good_friday_day", int'(exp_dates.good_friday_day),
						int'(good_friday_day));
					check_field("good_friday_month", int'(exp_dates.good_friday_month),
						int'(good_friday_month));
					check_field("easter_dom", int'(exp_dates.easter_dom), int'(easter_dom));
					check_field("easter_mon", int'(exp_dates.easter_mon), int'(easter_mon));
					check_field("ascension_day", int'(exp_dates.ascension_day),
						int'(ascension_day));
					check_field("ascension_month", int'(exp_dates.ascension_month),
						int'(ascension_month));
					check_field("whitsun_day", int'(exp_dates.whitsun_day),
						int'(whitsun_day));
					check_field("whitsun_month", int'(exp_dates.whitsun_month),
						int'(whitsun_month));
				end
			end
			if (start && !busy)
				dates_due.push_back(use_typed ? typed_dates : feast_dates_of(year));

			// watchdog: cycles in which no beat moves on either side
			if (done || (start && !busy))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
				$display("timeout: no beat for %0d cycles", WATCHDOG_MAX);
				$display("moveable_feast_dates_unit: mismatch");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Present one year; idle_pct is the chance per cycle of an idle gap first.
	// Returns after the accepting edge.
	task automatic send_year(int yr, bit typed, feast_dates_t dates, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		year        <= yr[mfd_pkg::YEAR_W-1:0];
		use_typed   <= typed;
		typed_dates <= dates;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Mostly years in the Gregorian range, the rest over all 14 bits
	function automatic int random_year();
		if ($urandom_range(99) < 70)
			return $urandom_range(9999, 1583);
		return $urandom_range(16383, 0);
	endfunction

	// Sender idle percentage per random phase. The third phase is the one
	// where only the receiver would stall; done can't be held off, so it
	// runs back to back like the first.
	int idle_by_phase [4] = '{0, 78, 0, 34};

	initial begin
		mismatches  = 0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		year        <= '0;
		use_typed   <= 1'b0;
		typed_dates <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed years, back to back
		foreach (year_rows[r])
			send_year(year_rows[r].yr, year_rows[r].typed, year_rows[r].dates, 0);

		// random years, checked against the predictor
		foreach (idle_by_phase[p])
			for (int n = 0; n < N_PER_PHASE; n++)
				send_year(random_year(), 1'b0, NO_DATES, idle_by_phase[p]);
		start <= 1'b0;

		// drain: the watchdog bounds this wait
		while (dates_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("moveable_feast_dates_unit: match");
		else
			$display("moveable_feast_dates_unit: mismatch");
		$finish;
	end

endmodule

>>> moveable_feast_dates_unit.f
rtl/mfd_pkg.sv
rtl/moveable_feast_dates_unit.sv
tb/moveable_feast_dates_unit_test.sv
